### rtl/core/fpm_pkg.sv
// ----------------------------------------------------------------------------
// fpm_pkg: shared types and constants
// Widths, window depth and register codes for the frame performance monitor.
// ----------------------------------------------------------------------------
package fpm_pkg;

  localparam int DATA_W = 16;                   // every count, rate and average
  localparam int DIV_W  = 2 * DATA_W;           // serial divider dividend width
  localparam int STEP_W = $clog2(DATA_W + 1);   // divider step counter

  localparam int WINDOW = 60;                   // ring depth, 1..256
  localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W  = $clog2(WINDOW * 65535 + 1);

  // floor(sum / WINDOW) as (sum * AVG_RECIP) >> AVG_SHIFT, exact for any
  // sum below 2**SUM_W since the reciprocal error stays under 2**(shift-SUM_W)
  localparam int AVG_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W   = SUM_W + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] AVG_RECIP =
    RECIP_W'(((longint'(1) << AVG_SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW));

  localparam int ENTRY_W = 2 * DATA_W;          // ring word: {rate, count}

  localparam logic [DATA_W-1:0] RATE_NUMERATOR  = 16'd10000;
  localparam logic [DATA_W-1:0] RATE_SATURATION = 16'hFFFF;
  localparam logic [DATA_W-1:0] PERIOD_RESET    = 16'd32768;
  localparam logic [DATA_W-1:0] OFFSET_RESET    = 16'd10950;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMER_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_OFFSET = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ALIGN = 6'b000010,
    S_COUNT = 6'b000100,
    S_DIVA  = 6'b001000,
    S_RATE  = 6'b010000,
    S_OUT   = 6'b100000
  } fpm_state_t;

endpackage

### rtl/core/fpm_ring_ram.sv
// ----------------------------------------------------------------------------
// fpm_ring_ram: single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fpm_ring_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 60,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/fpm_serial_div.sv
// ----------------------------------------------------------------------------
// fpm_serial_div: restoring divider, one quotient bit per cycle
// Produces a DATA_W-bit quotient. The upper half of the
// dividend must be below the divisor (quotient fits DATA_W bits).
// ----------------------------------------------------------------------------
module fpm_serial_div
  import fpm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              busy,
  output logic [DATA_W-1:0] quotient
);

  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] shift;      // low dividend bits out, quotient bits in
  logic [DATA_W-1:0] dsr;
  logic [STEP_W-1:0] step;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   rem_diff;
  logic              fits;

  assign rem_sh   = {rem, shift[DATA_W-1]};
  assign rem_diff = rem_sh - {1'b0, dsr};
  assign fits     = (rem_sh >= {1'b0, dsr});
  assign quotient = shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= STEP_W'(DATA_W);
    end else if (busy) begin
      step <= step - 1'b1;
      if (step == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= dividend[DIV_W-1:DATA_W];
      shift <= dividend[DATA_W-1:0];
      dsr   <= divisor;
    end else if (busy) begin
      rem   <= fits ? rem_diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      shift <= {shift[DATA_W-2:0], fits};
    end
  end

endmodule

### rtl/core/frame_performance_monitor_core.sv
// ----------------------------------------------------------------------------
// frame_performance_monitor_core: per-frame timing monitor
// Aligns the frame timer reading, tracks its min/max, derives a frame rate
// and keeps WINDOW-deep moving averages of both values in a ring RAM.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake              | payload
//  ----------+-----+------------------------+----------------------------------
//  s_axis    | in  | s_axis_tvalid/tready   | tdata: timer_count, elapsed_time
//  m_axis    | out | m_axis_tvalid/tready   | tdata: 6 x 16b results, tuser: sat
//  cfg       | in  | cfg_we (no wait)       | cfg_index, cfg_data
//
//  Sequencing: one transaction at a time, stepping S_ALIGN, S_COUNT, S_DIVA,
//    S_RATE and S_OUT before the result loads the output register; S_DIVA
//    waits on the 16-step serial rate divider. Both averages come from a
//    reciprocal multiply of the running sums.
//  Reset: rst clears min/max, sums, ring position and the per-entry valid
//    bits at once; no clearing pass over the ring RAM is needed.
//  Stalls: a new transaction is accepted while the previous result still
//    waits in the output register; the block holds in S_OUT only if that
//    result has still not been taken when the next one is done.
//  The ring is read and written at the same entry only within one
//    transaction, read first, so no forwarding path exists.
//
module frame_performance_monitor_core
  import fpm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,   // timer_count, elapsed_time
  // output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [95:0]          m_axis_tdata,   // adjusted_count, min_count,
                                               // max_count, count_average,
                                               // rate_value, rate_average
  output logic                 m_axis_tuser    // rate_saturated
);

  fpm_state_t state;

  // config registers
  logic [DATA_W-1:0] timer_period;
  logic [DATA_W-1:0] count_offset;

  // transaction payload
  logic [DATA_W-1:0] raw_q;
  logic [DATA_W-1:0] elapsed_q;
  logic [DATA_W-1:0] adj_q;
  logic [DATA_W-1:0] rate_q;
  logic [DATA_W-1:0] old_rate_q;

  // running state
  logic [DATA_W-1:0] min_seen;
  logic [DATA_W-1:0] max_seen;
  logic [POS_W-1:0]  pos;
  logic [WINDOW-1:0] ring_valid;
  logic [SUM_W-1:0]  count_sum;
  logic [SUM_W-1:0]  rate_sum;

  // alignment and sum updates
  logic [DATA_W-1:0] align_sum;
  logic [DATA_W-1:0] adj_calc;
  logic [DATA_W-1:0] old_count;
  logic [DATA_W-1:0] old_rate;
  logic [DATA_W-1:0] rate_val;
  logic [SUM_W-1:0]  count_sum_next;
  logic [SUM_W-1:0]  rate_sum_next;

  // window averages
  logic [PROD_W-1:0] count_prod;
  logic [PROD_W-1:0] rate_prod;
  logic [DATA_W-1:0] count_avg;
  logic [DATA_W-1:0] rate_avg;

  // ring RAM
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  // rate divider
  logic              rdiv_start, rdiv_busy;
  logic [DATA_W-1:0] rdiv_q;

  logic in_accept;
  logic out_load;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign out_load      = (state == S_OUT) && (!m_axis_tvalid || m_axis_tready);

  // offset alignment, 16-bit wrap, then one conditional period subtract
  assign align_sum = raw_q + timer_period - count_offset;
  assign adj_calc  = (align_sum > timer_period) ? align_sum - timer_period : align_sum;

  // entries never written read as zero
  assign old_count = ring_valid[pos] ? ram_rdata[DATA_W-1:0] : '0;
  assign old_rate  = ring_valid[pos] ? ram_rdata[ENTRY_W-1:DATA_W] : '0;

  assign rate_val = (elapsed_q == '0) ? RATE_SATURATION : rdiv_q;

  assign count_sum_next = count_sum - SUM_W'(old_count) + SUM_W'(adj_q);
  assign rate_sum_next  = rate_sum - SUM_W'(old_rate_q) + SUM_W'(rate_val);

  // floor(sum / WINDOW) by reciprocal multiply of the registered sums
  assign count_prod = PROD_W'(count_sum) * PROD_W'(AVG_RECIP);
  assign rate_prod  = PROD_W'(rate_sum) * PROD_W'(AVG_RECIP);
  assign count_avg  = count_prod[AVG_SHIFT +: DATA_W];
  assign rate_avg   = rate_prod[AVG_SHIFT +: DATA_W];

  assign ram_we    = (state == S_RATE);
  assign ram_wdata = {rate_val, adj_q};

  assign rdiv_start = (state == S_ALIGN);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_period <= PERIOD_RESET;
      count_offset <= OFFSET_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIMER_PERIOD: timer_period <= cfg_data;
        REG_COUNT_OFFSET: count_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and running state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      min_seen   <= '1;
      max_seen   <= '0;
      pos        <= '0;
      ring_valid <= '0;
      count_sum  <= '0;
      rate_sum   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= S_ALIGN;
          end
        end
        S_ALIGN: begin
          // ring read of pos issued this cycle, rate divide started
          if (adj_calc > max_seen) max_seen <= adj_calc;
          if (adj_calc < min_seen) min_seen <= adj_calc;
          state <= S_COUNT;
        end
        S_COUNT: begin
          count_sum <= count_sum_next;
          state     <= S_DIVA;
        end
        S_DIVA: begin
          if (!rdiv_busy) begin
            state <= S_RATE;
          end
        end
        S_RATE: begin
          rate_sum        <= rate_sum_next;
          ring_valid[pos] <= 1'b1;
          pos   <= (pos == POS_W'(WINDOW - 1)) ? '0 : pos + 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      raw_q     <= s_axis_tdata[15:0];
      elapsed_q <= s_axis_tdata[31:16];
    end
    if (state == S_ALIGN) begin
      adj_q <= adj_calc;
    end
    if (state == S_COUNT) begin
      old_rate_q <= old_rate;
    end
    if (state == S_RATE) begin
      rate_q <= rate_val;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {rate_avg, rate_q, count_avg, max_seen, min_seen, adj_q};
      m_axis_tuser <= (elapsed_q == '0);
    end
  end

  fpm_ring_ram #(
    .WIDTH  (ENTRY_W),
    .DEPTH  (WINDOW),
    .ADDR_W (POS_W)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos),
    .wdata (ram_wdata),
    .raddr (pos),
    .rdata (ram_rdata)
  );

  fpm_serial_div u_rate_div (
    .clk      (clk),
    .rst      (rst),
    .start    (rdiv_start),
    .dividend (DIV_W'(RATE_NUMERATOR)),
    .divisor  (elapsed_q),
    .busy     (rdiv_busy),
    .quotient (rdiv_q)
  );

`ifndef SYNTHESIS
  a_ready_no_div: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !rdiv_busy)
    else $error("input ready while the divider is busy");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(WINDOW - 1))
    else $error("ring position out of range");

  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    (count_sum <= SUM_W'(WINDOW * 65535)) && (rate_sum <= SUM_W'(WINDOW * 65535)))
    else $error("running sum exceeds ring capacity");

  a_write_marks_valid: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> ring_valid[$past(pos)])
    else $error("ring entry written but not marked valid");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> !$past(out_load))
    else $error("pending result overwritten");
`endif

endmodule
